### design/framed_byte_parser_with_sum_check_macros.svh
// Assertion macros used by the checker of the framed byte parser.
`ifndef FRAMED_BYTE_PARSER_WITH_SUM_CHECK_MACROS_SVH
`define FRAMED_BYTE_PARSER_WITH_SUM_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define FBP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/fbp_pkg.sv
// Shared types and constants of the framed byte parser.
package fbp_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned CsrIndexWidth = 8;

   localparam logic [ByteWidth-1:0] SyncFirstReset = 8'hAA;
   localparam logic [ByteWidth-1:0] SyncSecondReset = 8'h22;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CsrSyncFirst = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSyncSecond = 8'd1;

   // Parser phases.
   localparam logic [PhaseWidth-1:0] PhaseHunt = 3'd0;
   localparam logic [PhaseWidth-1:0] PhaseSync2 = 3'd1;
   localparam logic [PhaseWidth-1:0] PhaseFunc = 3'd2;
   localparam logic [PhaseWidth-1:0] PhaseLen = 3'd3;
   localparam logic [PhaseWidth-1:0] PhaseData = 3'd4;
   localparam logic [PhaseWidth-1:0] PhaseCheck = 3'd5;

   // Result kinds.
   localparam logic KindPayload = 1'b0;
   localparam logic KindFrameEnd = 1'b1;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [ByteWidth-1:0]  bytes_left;
      logic [ByteWidth-1:0]  running_sum;
      logic [ByteWidth-1:0]  held_function;
      logic [ByteWidth-1:0]  held_length;
      logic [ByteWidth-1:0]  payload_position;
   } parse_state_type;

   typedef struct packed {
      logic                 valid;
      logic                 item_kind;
      logic [ByteWidth-1:0] function_code;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] byte_index;
      logic [ByteWidth-1:0] frame_length;
      logic                 checksum_ok;
   } parse_result_type;

endpackage

### design/fbp_step.sv
// Next-state and result logic for one received byte of the frame parser.
module fbp_step (
   input  fbp_pkg::parse_state_type        state,
   input  logic [fbp_pkg::ByteWidth-1:0]   rx_byte,
   input  logic [fbp_pkg::ByteWidth-1:0]   sync_first,
   input  logic [fbp_pkg::ByteWidth-1:0]   sync_second,
   output fbp_pkg::parse_state_type        next_state,
   output fbp_pkg::parse_result_type       result
);

   logic [fbp_pkg::ByteWidth-1:0] sum_plus;

   assign sum_plus = state.running_sum + rx_byte;

   always_comb begin
      next_state = state;
      result = '0;
      result.function_code = state.held_function;
      result.frame_length = state.held_length;
      priority if (state.phase == fbp_pkg::PhaseHunt && rx_byte == sync_first) begin
         next_state.phase = fbp_pkg::PhaseSync2;
         next_state.running_sum = rx_byte;
      end else if (state.phase == fbp_pkg::PhaseSync2 && rx_byte == sync_second) begin
         next_state.phase = fbp_pkg::PhaseFunc;
         next_state.running_sum = sum_plus;
      end else if (state.phase == fbp_pkg::PhaseFunc) begin
         next_state.phase = fbp_pkg::PhaseLen;
         next_state.held_function = rx_byte;
         next_state.running_sum = sum_plus;
      end else if (state.phase == fbp_pkg::PhaseLen) begin
         next_state.phase = fbp_pkg::PhaseData;
         next_state.held_length = rx_byte;
         next_state.bytes_left = rx_byte;
         next_state.payload_position = '0;
         next_state.running_sum = sum_plus;
      end else if (state.phase == fbp_pkg::PhaseData && state.bytes_left != '0) begin
         result.valid = 1'b1;
         result.item_kind = fbp_pkg::KindPayload;
         result.payload_byte = rx_byte;
         result.byte_index = state.payload_position;
         next_state.running_sum = sum_plus;
         next_state.payload_position = state.payload_position + 1'b1;
         next_state.bytes_left = state.bytes_left - 1'b1;
         if (state.bytes_left == fbp_pkg::ByteWidth'(1)) begin
            next_state.phase = fbp_pkg::PhaseCheck;
         end
      end else if (state.phase == fbp_pkg::PhaseCheck) begin
         result.valid = 1'b1;
         result.item_kind = fbp_pkg::KindFrameEnd;
         result.checksum_ok = (state.running_sum == rx_byte);
         next_state.phase = fbp_pkg::PhaseHunt;
      end else begin
         // Covers a failed second sync, the byte after a zero length and stray bytes.
         next_state.phase = fbp_pkg::PhaseHunt;
      end
   end

endmodule

### design/framed_byte_parser_with_sum_check.sv
// Top level of the framed byte parser with additive checksum.
// The parser takes one received byte per clock cycle; each byte goes straight through
// the phase logic into the result register, so an accepted byte shows any result from the
// next cycle on. Input ready drops only while the result register holds an item that has
// not been taken, so with rsp_ready held high the block sustains one byte every cycle. A
// frame is two sync bytes, a function code, a length, that many payload bytes and a checksum
// equal to the 8-bit sum of all frame bytes before it; each payload byte comes out with its
// index and, for a nonzero length, the checksum byte produces a frame-end item with the
// verdict. Sync bytes are set through the csr_ port (index 0 first sync, index 1 second
// sync) by the user only while the block is idle; the block does not enforce it.
module framed_byte_parser_with_sum_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fbp_pkg::ByteWidth-1:0]        req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_item_kind,
   output logic [fbp_pkg::ByteWidth-1:0]        rsp_function_code,
   output logic [fbp_pkg::ByteWidth-1:0]        rsp_payload_byte,
   output logic [fbp_pkg::ByteWidth-1:0]        rsp_byte_index,
   output logic [fbp_pkg::ByteWidth-1:0]        rsp_frame_length,
   output logic                                 rsp_checksum_ok,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fbp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [fbp_pkg::ByteWidth-1:0]        csr_wdata
);

   fbp_pkg::parse_state_type      state_ff;
   fbp_pkg::parse_state_type      state_in;
   fbp_pkg::parse_result_type     step_result;
   fbp_pkg::parse_result_type     rsp_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [fbp_pkg::ByteWidth-1:0] sync_first_ff;
   logic [fbp_pkg::ByteWidth-1:0] sync_second_ff;
   logic                          req_accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   fbp_step u_step (
      .state       (state_ff),
      .rx_byte     (req_rx_byte),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .next_state  (state_in),
      .result      (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rsp_valid_in = step_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sync_first_ff <= fbp_pkg::SyncFirstReset;
         sync_second_ff <= fbp_pkg::SyncSecondReset;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_index == fbp_pkg::CsrSyncFirst) begin
            sync_first_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == fbp_pkg::CsrSyncSecond) begin
            sync_second_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_kind = rsp_ff.item_kind;
   assign rsp_function_code = rsp_ff.function_code;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_checksum_ok = rsp_ff.checksum_ok;

endmodule

### design/fbp_checker.sv
// Port-level checker of the framed byte parser and its bind statement.
`include "framed_byte_parser_with_sum_check_macros.svh"

module fbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_item_kind,
   input logic [fbp_pkg::ByteWidth-1:0] rsp_payload_byte,
   input logic [fbp_pkg::ByteWidth-1:0] rsp_byte_index,
   input logic [fbp_pkg::ByteWidth-1:0] rsp_frame_length,
   input logic                          rsp_checksum_ok
);

   // A result held back by the consumer stays on the port.
   `FBP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload_byte),
      "held result changed")

   // A result can only appear after an item was accepted.
   `FBP_ASSERT_NEXT(a_rsp_source, clock, reset,
      !(req_valid && req_ready) && !(rsp_valid && !rsp_ready), !rsp_valid,
      "result without an accepted item")

   // Payload items carry an index inside the announced length and no verdict.
   `FBP_ASSERT_NOW(a_payload_index, clock, reset,
      rsp_valid && rsp_item_kind == fbp_pkg::KindPayload,
      rsp_byte_index < rsp_frame_length && !rsp_checksum_ok,
      "payload item out of range")

   // Frame-end items carry zero payload fields.
   `FBP_ASSERT_NOW(a_end_fields, clock, reset,
      rsp_valid && rsp_item_kind == fbp_pkg::KindFrameEnd,
      rsp_payload_byte == '0 && rsp_byte_index == '0,
      "frame-end item with payload fields")

   // No result is shown right after reset.
   `FBP_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result right after reset")

endmodule

bind framed_byte_parser_with_sum_check fbp_checker u_fbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_item_kind    (rsp_item_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_frame_length (rsp_frame_length),
   .rsp_checksum_ok  (rsp_checksum_ok)
);
